// ===== design/dts_pkg.sv =====
// Shared types, constants and a helper function of the daily trigger scheduler.
`timescale 1ns / 1ps

package dts_pkg;

   localparam int MIN_W = 11;
   localparam int DAY_W = 9;
   localparam int OFF_W = 12;
   localparam int IDX_W = 3;
   localparam int DATA_W = 12;

   localparam logic [MIN_W-1:0] DAY_MINUTES = 11'd1440;

   typedef enum logic [1:0] {
      SRC_FIXED   = 2'd0,
      SRC_SUNRISE = 2'd1,
      SRC_SUNSET  = 2'd2,
      SRC_NONE    = 2'd3
   } source_type;

   typedef enum logic [1:0] {
      PHASE_NONE  = 2'd0,
      PHASE_START = 2'd1,
      PHASE_END   = 2'd2
   } phase_type;

   localparam logic [IDX_W-1:0] REG_ENABLE       = 3'd0;
   localparam logic [IDX_W-1:0] REG_START_SOURCE = 3'd1;
   localparam logic [IDX_W-1:0] REG_START_FIXED  = 3'd2;
   localparam logic [IDX_W-1:0] REG_START_OFFSET = 3'd3;
   localparam logic [IDX_W-1:0] REG_END_SOURCE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_END_FIXED    = 3'd5;
   localparam logic [IDX_W-1:0] REG_END_OFFSET   = 3'd6;

   typedef struct packed {
      source_type              source;
      logic [MIN_W-1:0]        fixed_minute;
      logic signed [OFF_W-1:0] offset;
   } trig_cfg_type;

   typedef struct packed {
      logic             known;
      logic [MIN_W-1:0] minute;
   } trig_time_type;

   typedef struct packed {
      logic             day_seen;
      logic [DAY_W-1:0] last_day;
      logic [MIN_W-1:0] prev_minute;
   } sched_state_type;

   typedef struct packed {
      phase_type        phase;
      logic             next_known;
      logic [MIN_W-1:0] next_minute;
      logic             next_is_start;
   } sched_result_type;

   // Reduces a value below twice the day length into one day.
   function automatic logic [MIN_W-1:0] fold_minute(input logic [MIN_W:0] value);
      logic [MIN_W:0] reduced;
      reduced = value - {1'b0, DAY_MINUTES};
      if (value >= {1'b0, DAY_MINUTES}) begin
         fold_minute = reduced[MIN_W-1:0];
      end else begin
         fold_minute = value[MIN_W-1:0];
      end
   endfunction

endpackage

// ===== design/dts_channels.sv =====
// Channel interfaces of the daily trigger scheduler: tick requests, results and register writes.
`timescale 1ns / 1ps

interface dts_req_if;
   logic                        valid;
   logic                        ready;
   logic [dts_pkg::MIN_W-1:0]   tick_minute;
   logic [dts_pkg::DAY_W-1:0]   day_of_year;
   logic [dts_pkg::MIN_W-1:0]   rise_minute;
   logic                        sunrise_known;
   logic [dts_pkg::MIN_W-1:0]   set_minute;
   logic                        sunset_known;

   modport source (output valid, tick_minute, day_of_year, rise_minute, sunrise_known,
                   set_minute, sunset_known, input ready);
   modport sink (input valid, tick_minute, day_of_year, rise_minute, sunrise_known,
                 set_minute, sunset_known, output ready);
endinterface

interface dts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  phase;
   logic                        next_known;
   logic [dts_pkg::MIN_W-1:0]   next_minute;
   logic                        next_is_start;

   modport source (output valid, phase, next_known, next_minute, next_is_start, input ready);
   modport sink (input valid, phase, next_known, next_minute, next_is_start, output ready);
endinterface

interface dts_csr_if;
   logic                        valid;
   logic                        ready;
   logic [dts_pkg::IDX_W-1:0]   index;
   logic [dts_pkg::DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/daily_trigger_scheduler.sv =====
// Top level of the daily trigger scheduler: registers, tick pipeline and result register.
// A request is held in the input register, and its result then in the result register.
// Throughput: one request per cycle while the result side takes results; a disabled tick yields none.
// Reset: synchronous, active high; clears both stages, the schedule state and the registers.
`timescale 1ns / 1ps

module daily_trigger_scheduler (
   input  logic        clock,
   input  logic        reset,
   dts_req_if.sink     req_chan,
   dts_rsp_if.source   rsp_chan,
   dts_csr_if.sink     csr_chan
);

   logic                         enable_ff;
   dts_pkg::trig_cfg_type        start_cfg_ff;
   dts_pkg::trig_cfg_type        end_cfg_ff;

   logic                         tick_valid_ff;
   logic [dts_pkg::MIN_W-1:0]    now_ff;
   logic [dts_pkg::DAY_W-1:0]    day_ff;
   logic [dts_pkg::MIN_W-1:0]    rise_ff;
   logic                         rise_known_ff;
   logic [dts_pkg::MIN_W-1:0]    set_ff;
   logic                         set_known_ff;

   dts_pkg::sched_state_type     state_ff;
   dts_pkg::sched_state_type     state_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   dts_pkg::sched_result_type    result_ff;
   dts_pkg::sched_result_type    result_in;

   logic [dts_pkg::MIN_W-1:0]    now_wrapped;
   logic [dts_pkg::MIN_W-1:0]    rise_wrapped;
   logic [dts_pkg::MIN_W-1:0]    set_wrapped;
   dts_pkg::trig_time_type       start_time;
   dts_pkg::trig_time_type       end_time;

   logic                         tick_advance;
   logic                         result_load;
   logic                         req_fire;
   logic                         csr_fire;

   assign csr_chan.ready = 1'b1;
   assign csr_fire = csr_chan.valid;

   // A disabled tick leaves without a result, so it never waits on the result side.
   assign tick_advance = tick_valid_ff && (!enable_ff || !rsp_valid_ff || rsp_chan.ready);
   assign result_load = tick_advance && enable_ff;
   assign req_chan.ready = !tick_valid_ff || tick_advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign now_wrapped = dts_pkg::fold_minute({1'b0, now_ff});
   assign rise_wrapped = dts_pkg::fold_minute({1'b0, rise_ff});
   assign set_wrapped = dts_pkg::fold_minute({1'b0, set_ff});

   dts_resolve u_start_resolve (
      .cfg            (start_cfg_ff),
      .rise_minute    (rise_wrapped),
      .sunrise_known  (rise_known_ff),
      .set_minute     (set_wrapped),
      .sunset_known   (set_known_ff),
      .trig_time      (start_time)
   );

   dts_resolve u_end_resolve (
      .cfg            (end_cfg_ff),
      .rise_minute    (rise_wrapped),
      .sunrise_known  (rise_known_ff),
      .set_minute     (set_wrapped),
      .sunset_known   (set_known_ff),
      .trig_time      (end_time)
   );

   dts_decide u_decide (
      .tick_minute (now_wrapped),
      .day_of_year (day_ff),
      .start_time  (start_time),
      .end_time    (end_time),
      .state       (state_ff),
      .result      (result_in)
   );

   // Every enabled tick records its day and minute, whether or not the day changed.
   always_comb begin
      state_in = state_ff;
      if (result_load) begin
         state_in.day_seen = 1'b1;
         state_in.last_day = day_ff;
         state_in.prev_minute = now_wrapped;
      end
   end

   always_comb begin
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         start_cfg_ff.source <= dts_pkg::SRC_NONE;
         start_cfg_ff.fixed_minute <= '0;
         start_cfg_ff.offset <= '0;
         end_cfg_ff.source <= dts_pkg::SRC_NONE;
         end_cfg_ff.fixed_minute <= '0;
         end_cfg_ff.offset <= '0;
      end else if (csr_fire) begin
         case (csr_chan.index)
            dts_pkg::REG_ENABLE: enable_ff <= csr_chan.data[0];
            dts_pkg::REG_START_SOURCE: begin
               start_cfg_ff.source <= dts_pkg::source_type'(csr_chan.data[1:0]);
            end
            dts_pkg::REG_START_FIXED: begin
               start_cfg_ff.fixed_minute <= csr_chan.data[dts_pkg::MIN_W-1:0];
            end
            dts_pkg::REG_START_OFFSET: start_cfg_ff.offset <= csr_chan.data;
            dts_pkg::REG_END_SOURCE: begin
               end_cfg_ff.source <= dts_pkg::source_type'(csr_chan.data[1:0]);
            end
            dts_pkg::REG_END_FIXED: begin
               end_cfg_ff.fixed_minute <= csr_chan.data[dts_pkg::MIN_W-1:0];
            end
            dts_pkg::REG_END_OFFSET: end_cfg_ff.offset <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            tick_valid_ff <= 1'b1;
         end else if (tick_advance) begin
            tick_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff <= req_chan.tick_minute;
         day_ff <= req_chan.day_of_year;
         rise_ff <= req_chan.rise_minute;
         rise_known_ff <= req_chan.sunrise_known;
         set_ff <= req_chan.set_minute;
         set_known_ff <= req_chan.sunset_known;
      end
      if (result_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.phase = result_ff.phase;
   assign rsp_chan.next_known = result_ff.next_known;
   assign rsp_chan.next_minute = result_ff.next_minute;
   assign rsp_chan.next_is_start = result_ff.next_is_start;

endmodule

// ===== design/dts_resolve.sv =====
// Resolves one trigger time from its registers and the sunrise and sunset of the tick.
`timescale 1ns / 1ps

module dts_resolve (
   input  dts_pkg::trig_cfg_type        cfg,
   input  logic [dts_pkg::MIN_W-1:0]    rise_minute,
   input  logic                         sunrise_known,
   input  logic [dts_pkg::MIN_W-1:0]    set_minute,
   input  logic                         sunset_known,
   output dts_pkg::trig_time_type       trig_time
);

   logic signed [dts_pkg::OFF_W:0] offset_ext;
   logic signed [dts_pkg::OFF_W:0] offset_adj;
   logic [dts_pkg::MIN_W-1:0]      offset_wrapped;
   logic [dts_pkg::MIN_W-1:0]      base_minute;
   logic [dts_pkg::MIN_W:0]        sum;
   logic [dts_pkg::MIN_W-1:0]      shifted_minute;

   // The offset is first brought into one day, so that one conditional subtract
   // finishes the wrap of the sum.
   always_comb begin
      offset_ext = {cfg.offset[dts_pkg::OFF_W-1], cfg.offset};
      if (offset_ext < -13'sd1440) begin
         offset_adj = offset_ext + 13'sd2880;
      end else if (offset_ext < 13'sd0) begin
         offset_adj = offset_ext + 13'sd1440;
      end else if (offset_ext >= 13'sd1440) begin
         offset_adj = offset_ext - 13'sd1440;
      end else begin
         offset_adj = offset_ext;
      end
      offset_wrapped = offset_adj[dts_pkg::MIN_W-1:0];
   end

   assign base_minute = (cfg.source == dts_pkg::SRC_SUNRISE) ? rise_minute : set_minute;
   assign sum = {1'b0, base_minute} + {1'b0, offset_wrapped};
   assign shifted_minute = dts_pkg::fold_minute(sum);

   always_comb begin
      trig_time.known = 1'b0;
      trig_time.minute = '0;
      case (cfg.source)
         dts_pkg::SRC_FIXED: begin
            trig_time.known = (cfg.fixed_minute < dts_pkg::DAY_MINUTES);
            trig_time.minute = cfg.fixed_minute;
         end
         dts_pkg::SRC_SUNRISE: begin
            trig_time.known = sunrise_known;
            trig_time.minute = shifted_minute;
         end
         dts_pkg::SRC_SUNSET: begin
            trig_time.known = sunset_known;
            trig_time.minute = shifted_minute;
         end
         default: begin
            trig_time.known = 1'b0;
            trig_time.minute = '0;
         end
      endcase
   end

endmodule

// ===== design/dts_decide.sv =====
// Decides the due event and the nearest upcoming event of one tick.
`timescale 1ns / 1ps

module dts_decide (
   input  logic [dts_pkg::MIN_W-1:0]    tick_minute,
   input  logic [dts_pkg::DAY_W-1:0]    day_of_year,
   input  dts_pkg::trig_time_type       start_time,
   input  dts_pkg::trig_time_type       end_time,
   input  dts_pkg::sched_state_type     state,
   output dts_pkg::sched_result_type    result
);

   // Forward distance from one minute of day to another, wrapping past midnight.
   function automatic logic [dts_pkg::MIN_W-1:0] fwd(input logic [dts_pkg::MIN_W-1:0] from,
                                                    input logic [dts_pkg::MIN_W-1:0] to);
      logic [dts_pkg::MIN_W-1:0] diff;
      diff = to - from;
      if (to >= from) begin
         fwd = diff;
      end else begin
         fwd = diff + dts_pkg::DAY_MINUTES;
      end
   endfunction

   logic [dts_pkg::MIN_W-1:0] start_ahead;
   logic [dts_pkg::MIN_W-1:0] end_ahead;
   logic [dts_pkg::MIN_W-1:0] elapsed;
   logic [dts_pkg::MIN_W-1:0] start_since;
   logic [dts_pkg::MIN_W-1:0] end_since;
   logic                      same_day;
   logic                      pick_end;

   assign start_ahead = fwd(tick_minute, start_time.minute);
   assign end_ahead = fwd(tick_minute, end_time.minute);
   assign elapsed = fwd(state.prev_minute, tick_minute);
   assign start_since = fwd(state.prev_minute, start_time.minute);
   assign end_since = fwd(state.prev_minute, end_time.minute);
   assign same_day = state.day_seen && (state.last_day == day_of_year);
   assign pick_end = end_time.known && (!start_time.known || (end_ahead < start_ahead));

   always_comb begin
      result.phase = dts_pkg::PHASE_NONE;
      if (same_day && (elapsed != '0) && start_time.known && end_time.known) begin
         if ((start_since != '0) && (start_since <= elapsed)) begin
            result.phase = dts_pkg::PHASE_START;
         end else if ((end_since != '0) && (end_since <= elapsed)) begin
            result.phase = dts_pkg::PHASE_END;
         end
      end

      result.next_known = start_time.known || end_time.known;
      if (pick_end) begin
         result.next_minute = end_time.minute;
         result.next_is_start = 1'b0;
      end else if (start_time.known) begin
         result.next_minute = start_time.minute;
         result.next_is_start = 1'b1;
      end else begin
         result.next_minute = '0;
         result.next_is_start = 1'b0;
      end
   end

endmodule

// ===== design/dts_checker.sv =====
// Port-level checker of the daily trigger scheduler and its bind to the top level.
`timescale 1ns / 1ps

module dts_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_phase,
   input  logic                      rsp_next_known,
   input  logic [dts_pkg::MIN_W-1:0] rsp_next_minute,
   input  logic                      rsp_next_is_start
);

   // A stalled result keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // An unresolved schedule reports a zero upcoming event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_next_known |-> (rsp_next_minute == '0) && !rsp_next_is_start)
      else $error("unknown upcoming event carries data");

   // A resolved upcoming event lies within one day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_known |-> (rsp_next_minute < dts_pkg::DAY_MINUTES))
      else $error("upcoming minute beyond one day");

   // A due event is a start or an end and implies that some event resolved.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase != dts_pkg::PHASE_NONE) |-> rsp_next_known &&
         ((rsp_phase == dts_pkg::PHASE_START) || (rsp_phase == dts_pkg::PHASE_END)))
      else $error("due event without a resolved schedule");

   // No result is pending right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind daily_trigger_scheduler dts_checker u_dts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_phase         (rsp_chan.phase),
   .rsp_next_known    (rsp_chan.next_known),
   .rsp_next_minute   (rsp_chan.next_minute),
   .rsp_next_is_start (rsp_chan.next_is_start)
);

// ===== tb/dts_scoreboard.sv =====
// Scoreboard package for the daily trigger scheduler: register mirror, predictor and result check.
`timescale 1ns / 1ps

package dts_check_pkg;

   import dts_pkg::*;

   localparam int DAY_LEN = DAY_MINUTES;
   localparam int NONE_AHEAD = DAY_LEN + 1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [MIN_W-1:0] tick_minute;
      logic [DAY_W-1:0] day_of_year;
      logic [MIN_W-1:0] rise_minute;
      logic             sunrise_known;
      logic [MIN_W-1:0] set_minute;
      logic             sunset_known;
   } tick_req_type;

   class schedule_scoreboard;
      logic             enable;
      trig_cfg_type     start_cfg;
      trig_cfg_type     end_cfg;
      bit               day_seen;
      logic [DAY_W-1:0] last_day;
      int               prev_minute;
      sched_result_type due_results[$];
      int               mismatches;

      function new();
         enable = 1'b0;
         start_cfg = '{SRC_NONE, '0, '0};
         end_cfg = '{SRC_NONE, '0, '0};
         day_seen = 1'b0;
         last_day = '0;
         prev_minute = 0;
         mismatches = 0;
      endfunction

      function int day_wrap(int value);
         int r;
         r = value % DAY_LEN;
         if (r < 0) r += DAY_LEN;
         return r;
      endfunction

      function int minutes_ahead(int from_m, int to_m);
         int d;
         d = to_m - from_m;
         if (d < 0) d += DAY_LEN;
         return d;
      endfunction

      // An unresolved trigger time is returned as -1.
      function int trigger_minute(trig_cfg_type c, tick_req_type t);
         int off;
         off = $signed(c.offset);
         case (c.source)
            SRC_FIXED: return (c.fixed_minute < DAY_MINUTES) ? int'(c.fixed_minute) : -1;
            SRC_SUNRISE: return t.sunrise_known ?
                                day_wrap(day_wrap(int'(t.rise_minute)) + off) : -1;
            SRC_SUNSET: return t.sunset_known ?
                               day_wrap(day_wrap(int'(t.set_minute)) + off) : -1;
            default: return -1;
         endcase
      endfunction

      function void mirror_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            REG_ENABLE: enable = data[0];
            REG_START_SOURCE: start_cfg.source = source_type'(data[1:0]);
            REG_START_FIXED: start_cfg.fixed_minute = data[MIN_W-1:0];
            REG_START_OFFSET: start_cfg.offset = data;
            REG_END_SOURCE: end_cfg.source = source_type'(data[1:0]);
            REG_END_FIXED: end_cfg.fixed_minute = data[MIN_W-1:0];
            REG_END_OFFSET: end_cfg.offset = data;
            default: ;
         endcase
      endfunction

      function void note_tick(tick_req_type t);
         int now_m, st, en, best, span, sd, ed, d, j;
         int cand[2];
         sched_result_type r;
         if (!enable) return;
         now_m = day_wrap(int'(t.tick_minute));
         st = trigger_minute(start_cfg, t);
         en = trigger_minute(end_cfg, t);
         cand[0] = st;
         cand[1] = en;
         best = NONE_AHEAD;
         r.phase = PHASE_NONE;
         r.next_known = 1'b0;
         r.next_minute = '0;
         r.next_is_start = 1'b0;
         for (j = 0; j < 2; j++) begin
            if (cand[j] >= 0) begin
               d = minutes_ahead(now_m, cand[j]);
               if (d < best) begin
                  best = d;
                  r.next_known = 1'b1;
                  r.next_minute = MIN_W'(cand[j]);
                  r.next_is_start = (j == 0);
               end
            end
         end
         if (!day_seen || last_day != t.day_of_year) begin
            day_seen = 1'b1;
            last_day = t.day_of_year;
         end else begin
            span = minutes_ahead(prev_minute, now_m);
            if (span != 0 && st >= 0 && en >= 0) begin
               sd = minutes_ahead(prev_minute, st);
               ed = minutes_ahead(prev_minute, en);
               if (sd > 0 && sd <= span) r.phase = PHASE_START;
               else if (ed > 0 && ed <= span) r.phase = PHASE_END;
            end
         end
         prev_minute = now_m;
         due_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] phase, logic known, logic [MIN_W-1:0] minute,
                                 logic is_start);
         sched_result_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result phase %0d known %0d minute %0d start %0d",
                        $time, phase, known, minute, is_start);
            return;
         end
         want = due_results.pop_front();
         if (phase !== want.phase || known !== want.next_known ||
             minute !== want.next_minute || is_start !== want.next_is_start) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: phase/known/minute/start expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        $time, want.phase, want.next_known, want.next_minute,
                        want.next_is_start, phase, known, minute, is_start);
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function int failures();
         return mismatches + due_results.size();
      endfunction
   endclass

endpackage

// ===== tb/daily_trigger_scheduler_test.sv =====
// Testbench top of the daily trigger scheduler: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module daily_trigger_scheduler_test;

   import dts_pkg::*;
   import dts_check_pkg::*;

   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int LONG_HOLD = 60;
   localparam int PHASES = 10;
   localparam int DISABLED_PHASE = 5;
   localparam int HOLD_PHASE = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dts_req_if req_if();
   dts_rsp_if rsp_if();
   dts_csr_if csr_if();

   daily_trigger_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   schedule_scoreboard board = new();

   int req_gap_pct = 15;
   int rsp_idle_pct = 15;
   int hold_asks = 0;
   int day_now, minute_now, rise_now, set_now;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      tick_req_type seen;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) board.mirror_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) begin
            seen.tick_minute = req_if.tick_minute;
            seen.day_of_year = req_if.day_of_year;
            seen.rise_minute = req_if.rise_minute;
            seen.sunrise_known = req_if.sunrise_known;
            seen.set_minute = req_if.set_minute;
            seen.sunset_known = req_if.sunset_known;
            board.note_tick(seen);
         end
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.phase, rsp_if.next_known, rsp_if.next_minute,
                               rsp_if.next_is_start);
      end
   end

   // Result side: short random stalls, plus one long hold-off on request.
   initial begin
      int stall_left, holds_seen;
      stall_left = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            stall_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            stall_left = $urandom_range(0, 8);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_tick(input tick_req_type t);
      if ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.tick_minute <= t.tick_minute;
      req_if.day_of_year <= t.day_of_year;
      req_if.rise_minute <= t.rise_minute;
      req_if.sunrise_known <= t.sunrise_known;
      req_if.set_minute <= t.set_minute;
      req_if.sunset_known <= t.sunset_known;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic apply_settings(input bit en, input source_type ss, input int sf, input int so,
                                 input source_type es, input int ef, input int eo);
      logic [DATA_W-1:0] junk;
      junk = DATA_W'($urandom);
      put_reg(REG_ENABLE, {junk[11:1], en});
      put_reg(REG_START_SOURCE, {junk[11:2], ss});
      put_reg(REG_START_FIXED, {junk[11], sf[10:0]});
      put_reg(REG_START_OFFSET, so[11:0]);
      put_reg(REG_END_SOURCE, {junk[10:1], es});
      put_reg(REG_END_FIXED, {junk[0], ef[10:0]});
      put_reg(REG_END_OFFSET, eo[11:0]);
      put_reg(REG_UNUSED, junk);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tick_req_type tick_of(input int now_m, input int day, input int rise_m,
                                            input bit rise_ok, input int set_m,
                                            input bit set_ok);
      tick_req_type t;
      t.tick_minute = now_m[10:0];
      t.day_of_year = day[8:0];
      t.rise_minute = rise_m[10:0];
      t.sunrise_known = rise_ok;
      t.set_minute = set_m[10:0];
      t.sunset_known = set_ok;
      return t;
   endfunction

   function automatic source_type pick_source();
      int r;
      r = $urandom_range(9);
      if (r < 3) return SRC_FIXED;
      if (r < 6) return SRC_SUNRISE;
      if (r < 9) return SRC_SUNSET;
      return SRC_NONE;
   endfunction

   function automatic int pick_fixed();
      case ($urandom_range(9))
         0: return 0;
         1: return 1439;
         2: return $urandom_range(1440, 2047);
         default: return $urandom_range(0, 1439);
      endcase
   endfunction

   function automatic int pick_offset();
      case ($urandom_range(11))
         0: return -2048;
         1: return 2047;
         2: return -1439;
         3: return 1439;
         4: return 0;
         5: return $urandom_range(0, 4095);
         default: return int'($urandom_range(0, 2878)) - 1439;
      endcase
   endfunction

   // Mostly a steadily advancing clock within one day, with rare day changes and some noise.
   task automatic random_ticks(input int count);
      tick_req_type t;
      int n, kind;
      for (n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            day_now = (day_now + 1) % 366;
            minute_now = $urandom_range(0, 120);
            rise_now = $urandom_range(240, 480);
            set_now = $urandom_range(960, 1260);
         end else begin
            minute_now = (minute_now + $urandom_range(0, 45)) % 1440;
         end
         t = tick_of(minute_now, day_now, rise_now, $urandom_range(19) != 0,
                     set_now, $urandom_range(19) != 0);
         if (kind >= 94) begin
            t.tick_minute = MIN_W'($urandom_range(0, 2047));
            t.day_of_year = DAY_W'($urandom_range(0, 511));
            t.rise_minute = MIN_W'($urandom_range(0, 2047));
            t.sunrise_known = 1'($urandom_range(1));
            t.set_minute = MIN_W'($urandom_range(0, 2047));
            t.sunset_known = 1'($urandom_range(1));
         end
         send_tick(t);
      end
   endtask

   initial begin
      int p;
      req_if.valid <= 1'b0;
      req_if.tick_minute <= '0;
      req_if.day_of_year <= '0;
      req_if.rise_minute <= '0;
      req_if.sunrise_known <= 1'b0;
      req_if.set_minute <= '0;
      req_if.sunset_known <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The schedule is disabled out of reset, so this tick must yield nothing.
      send_tick(tick_of(500, 10, 400, 1, 1100, 1));
      drain();

      apply_settings(1, SRC_FIXED, 600, 2047, SRC_SUNSET, 2047, 30);
      send_tick(tick_of(500, 10, 400, 1, 1100, 1));
      send_tick(tick_of(500, 10, 400, 1, 1100, 1));
      send_tick(tick_of(600, 10, 400, 1, 1100, 1));
      send_tick(tick_of(1130, 10, 400, 1, 1100, 1));
      send_tick(tick_of(2047, 10, 400, 1, 1100, 1));
      send_tick(tick_of(700, 11, 400, 1, 1100, 1));
      send_tick(tick_of(900, 11, 400, 1, 1100, 0));
      send_tick(tick_of(1439, 11, 2047, 1, 2047, 1));
      send_tick(tick_of(0, 511, 0, 0, 0, 0));
      send_tick(tick_of(1439, 511, 1439, 0, 1439, 0));
      drain();

      // Equal start and end times: start wins both the due event and the next event.
      apply_settings(1, SRC_FIXED, 800, -1439, SRC_FIXED, 800, 1439);
      send_tick(tick_of(700, 20, 300, 1, 1000, 1));
      send_tick(tick_of(800, 20, 300, 1, 1000, 1));
      drain();

      apply_settings(1, SRC_SUNRISE, 0, -2048, SRC_SUNSET, 1439, 2047);
      send_tick(tick_of(0, 30, 0, 1, 1439, 1));
      send_tick(tick_of(1439, 30, 0, 1, 1439, 1));
      drain();

      apply_settings(1, SRC_FIXED, 1440, 0, SRC_NONE, 0, 0);
      send_tick(tick_of(100, 40, 300, 1, 1000, 1));
      drain();

      // A disabled tick must leave the recorded day and minute untouched.
      apply_settings(0, SRC_FIXED, 150, 0, SRC_FIXED, 180, 0);
      send_tick(tick_of(5, 41, 300, 1, 1000, 1));
      drain();
      apply_settings(1, SRC_FIXED, 150, 0, SRC_FIXED, 180, 0);
      send_tick(tick_of(160, 40, 300, 1, 1000, 1));
      send_tick(tick_of(200, 40, 300, 1, 1000, 1));
      drain();

      day_now = 100;
      minute_now = 0;
      rise_now = 360;
      set_now = 1080;
      for (p = 0; p < PHASES; p++) begin
         drain();
         apply_settings(p != DISABLED_PHASE, pick_source(), pick_fixed(), pick_offset(),
                        pick_source(), pick_fixed(), pick_offset());
         if (p == PHASES - 1) begin
            req_gap_pct = 0;
            rsp_idle_pct <= 0;
         end else if (p == HOLD_PHASE) begin
            req_gap_pct = 0;
            rsp_idle_pct <= 0;
            hold_asks <= hold_asks + 1;
         end else begin
            req_gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            rsp_idle_pct <= ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
         end
         random_ticks((p == DISABLED_PHASE) ? 20 : 70);
      end

      drain();
      if (board.failures() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dts_pkg.sv
design/dts_channels.sv
design/dts_resolve.sv
design/dts_decide.sv
design/daily_trigger_scheduler.sv
design/dts_checker.sv
tb/dts_scoreboard.sv
tb/daily_trigger_scheduler_test.sv
